FILE: design/cs0u8_pkg.sv
// ----------------------------------------------------------------------------
// cs0u8_pkg
// Shared types and constants for the CS0 to UTF-8 decoder: the job word that
// passes from the classifier to the byte serializer, and UTF-8 lead patterns.
// ----------------------------------------------------------------------------
package cs0u8_pkg;

    localparam logic [7:0]  UTF8_LEAD2    = 8'hc0;
    localparam logic [7:0]  UTF8_LEAD3    = 8'he0;
    localparam logic [7:0]  UTF8_CONT     = 8'h80;
    localparam logic [5:0]  UTF8_CONT_MSK = 6'h3f;
    localparam logic [15:0] UTF8_MAX1     = 16'h0080;
    localparam logic [15:0] UTF8_MAX2     = 16'h0800;

    localparam logic [7:0]  CID_BYTE_A = 8'd8;
    localparam logic [7:0]  CID_BYTE_B = 8'd254;
    localparam logic [7:0]  CID_PAIR_A = 8'd16;
    localparam logic [7:0]  CID_PAIR_B = 8'd255;

    // One classified input word: a character to encode (nchar bytes, 0..3)
    // followed by an optional end-of-string item.
    typedef struct packed {
        logic [15:0] code;
        logic [1:0]  nchar;
        logic        eos;
        logic        bad;
    } job_t;

    function automatic logic [1:0] utf8_len(input logic [15:0] c);
        logic [1:0] n;
        if (c < UTF8_MAX1)
            n = 2'd1;
        else if (c < UTF8_MAX2)
            n = 2'd2;
        else
            n = 2'd3;
        return n;
    endfunction

endpackage

FILE: design/cs0u8_front.sv
// ----------------------------------------------------------------------------
// cs0u8_front
// Accepts CS0 bytes, tracks the compression id and pair state, and turns each
// word into a job for the serializer. Words that yield nothing make no job.
// ----------------------------------------------------------------------------
module cs0u8_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  logic [7:0]          in_byte,
    input  logic                is_last,
    input  logic                job_full,
    output logic                job_wr,
    output cs0u8_pkg::job_t     job_data
);
    import cs0u8_pkg::*;

    localparam logic [2:0] PH_ID   = 3'd0;
    localparam logic [2:0] PH_BYTE = 3'd1;
    localparam logic [2:0] PH_PAIR = 3'd2;
    localparam logic [2:0] PH_STOP = 3'd3;
    localparam logic [2:0] PH_BAD  = 3'd4;

    logic [2:0] phase_reg, phase_next, phase_step;
    logic [7:0] held_reg, held_next;
    logic       odd_reg, odd_next;
    logic       accept;
    logic [15:0] pair_code;
    job_t       job;

    assign full      = job_full;
    assign accept    = push && !job_full;
    assign pair_code = {held_reg, in_byte};

    always_comb
    begin
        phase_step = phase_reg;
        held_next  = held_reg;
        odd_next   = odd_reg;
        job.code   = 16'd0;
        job.nchar  = 2'd0;
        job.eos    = is_last;
        job.bad    = 1'b0;
        unique case (phase_reg)
            PH_ID:
            begin
                if (in_byte == CID_BYTE_A || in_byte == CID_BYTE_B)
                    phase_step = PH_BYTE;
                else if (in_byte == CID_PAIR_A || in_byte == CID_PAIR_B)
                    phase_step = PH_PAIR;
                else
                    phase_step = PH_BAD;
                held_next = 8'd0;
                odd_next  = 1'b0;
            end
            PH_BYTE:
            begin
                if (in_byte == 8'd0)
                    phase_step = PH_STOP;
                else
                begin
                    job.code  = {8'd0, in_byte};
                    job.nchar = utf8_len({8'd0, in_byte});
                end
            end
            PH_PAIR:
            begin
                if (!odd_reg)
                begin
                    held_next = in_byte;
                    odd_next  = 1'b1;
                end
                else
                begin
                    held_next = 8'd0;
                    odd_next  = 1'b0;
                    if (pair_code == 16'd0)
                        phase_step = PH_STOP;
                    else
                    begin
                        job.code  = pair_code;
                        job.nchar = utf8_len(pair_code);
                    end
                end
            end
            default:
            begin
                // stopped or bad id: drop data bytes
            end
        endcase
        job.bad = is_last && (phase_step == PH_BAD);
        // end of string returns everything to reset
        if (is_last)
        begin
            phase_next = PH_ID;
            held_next  = 8'd0;
            odd_next   = 1'b0;
        end
        else
            phase_next = phase_step;
    end

    assign job_wr   = accept && (job.eos || job.nchar != 2'd0);
    assign job_data = job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_ID;
            held_reg  <= 8'd0;
            odd_reg   <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            held_reg  <= held_next;
            odd_reg   <= odd_next;
        end
    end

endmodule

FILE: design/cs0u8_jobq.sv
// ----------------------------------------------------------------------------
// cs0u8_jobq
// Small first-in first-out queue of jobs between classifier and serializer.
// ----------------------------------------------------------------------------
module cs0u8_jobq #(
    parameter int DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  cs0u8_pkg::job_t     wr_data,
    output logic                full,
    input  logic                rd_en,
    output cs0u8_pkg::job_t     rd_data,
    output logic                empty
);
    import cs0u8_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wptr_reg, rptr_reg;
    logic [CW-1:0] cnt_reg;
    logic          do_wr, do_rd;

    assign full    = (cnt_reg == CNT_FULL);
    assign empty   = (cnt_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wptr_reg <= (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
            if (do_rd)
                rptr_reg <= (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
            if (do_wr && !do_rd)
                cnt_reg <= cnt_reg + 1'b1;
            else if (do_rd && !do_wr)
                cnt_reg <= cnt_reg - 1'b1;
        end
    end

endmodule

FILE: design/cs0u8_back.sv
// ----------------------------------------------------------------------------
// cs0u8_back
// Takes jobs from the queue and emits their UTF-8 bytes and end item one word
// per cycle, while the output register is empty or popped, into that register.
// ----------------------------------------------------------------------------
module cs0u8_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                job_empty,
    output logic                job_rd,
    input  cs0u8_pkg::job_t     job_data,
    output logic [7:0]          out_byte,
    output logic                end_of_string,
    output logic                bad_id,
    output logic                run_last,
    output logic                empty,
    input  logic                pop
);
    import cs0u8_pkg::*;

    job_t       cur_reg;
    logic       cur_valid_reg;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] byte_reg, byte_sel;
    logic       eos_reg, bad_reg, last_reg;
    logic [2:0] total;
    logic       is_final, is_eos_item, load, take;

    assign total       = {1'b0, cur_reg.nchar} + {2'b0, cur_reg.eos};
    assign is_final    = ({1'b0, idx_reg} + 3'd1) == total;
    assign is_eos_item = (idx_reg == cur_reg.nchar);
    assign load        = cur_valid_reg && (!out_valid_reg || pop);
    assign take        = !job_empty && (!cur_valid_reg || (load && is_final));
    assign job_rd      = take;

    always_comb
    begin
        byte_sel = 8'd0;
        if (!is_eos_item)
        begin
            unique case (cur_reg.nchar)
                2'd1: byte_sel = cur_reg.code[7:0];
                2'd2:
                begin
                    if (idx_reg == 2'd0)
                        byte_sel = UTF8_LEAD2 | {3'b0, cur_reg.code[10:6]};
                    else
                        byte_sel = UTF8_CONT | {2'b0, cur_reg.code[5:0] & UTF8_CONT_MSK};
                end
                2'd3:
                begin
                    unique case (idx_reg)
                        2'd0:    byte_sel = UTF8_LEAD3 | {4'b0, cur_reg.code[15:12]};
                        2'd1:    byte_sel = UTF8_CONT | {2'b0, cur_reg.code[11:6]};
                        default: byte_sel = UTF8_CONT | {2'b0, cur_reg.code[5:0]};
                    endcase
                end
                default: byte_sel = 8'd0;
            endcase
        end
    end

    always_comb
    begin
        if (load)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;

        if (take)
            idx_next = 2'd0;
        else if (load)
            idx_next = idx_reg + 2'd1;
        else
            idx_next = idx_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            if (take)
                cur_valid_reg <= 1'b1;
            else if (load && is_final)
                cur_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            cur_reg <= job_data;
        if (load)
        begin
            byte_reg <= byte_sel;
            eos_reg  <= is_eos_item;
            bad_reg  <= is_eos_item && cur_reg.bad;
            last_reg <= is_final;
        end
    end

    assign out_byte      = byte_reg;
    assign end_of_string = eos_reg;
    assign bad_id        = bad_reg;
    assign run_last      = last_reg;
    assign empty         = !out_valid_reg;

endmodule

FILE: design/cs0_to_utf8_decoder_top.sv
// ----------------------------------------------------------------------------
// cs0_to_utf8_decoder_top
// Converts a UDF CS0 string, one byte per word, into UTF-8 bytes.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: drive in_byte/is_last and raise push; a word is taken at
//   an edge with push high and full low. The first byte of a string is the
//   compression id; is_last marks the final byte.
//   Result queue side: while empty is low, out_byte, end_of_string, bad_id and
//   run_last show the oldest result; pop takes it. run_last flags the final
//   result caused by one input word; the last input byte adds an end item.
// Timing:
//   The first result of a word passes the job queue, the current-job register
//   and the output register before it is visible. Input words are taken every
//   cycle while the job queue (JOB_DEPTH entries) has room; results leave at
//   one per cycle from the output register while pop is high. Words that
//   yield nothing pass through the classifier without a queue entry.
// Reset:
//   rst_n clears the decoder to expect a compression id and empties the queue
//   and output register. A stalled result side fills the job queue and then
//   raises full; nothing is lost.
// ----------------------------------------------------------------------------
module cs0_to_utf8_decoder_top #(
    parameter int JOB_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] in_byte,
    input  logic       is_last,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] out_byte,
    output logic       end_of_string,
    output logic       bad_id,
    output logic       run_last
);
    import cs0u8_pkg::*;

    job_t wr_job, rd_job;
    logic job_wr, job_rd, job_full, job_empty;

    cs0u8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .in_byte  (in_byte),
        .is_last  (is_last),
        .job_full (job_full),
        .job_wr   (job_wr),
        .job_data (wr_job)
    );

    cs0u8_jobq #(
        .DEPTH (JOB_DEPTH)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data (wr_job),
        .full    (job_full),
        .rd_en   (job_rd),
        .rd_data (rd_job),
        .empty   (job_empty)
    );

    cs0u8_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .job_empty     (job_empty),
        .job_rd        (job_rd),
        .job_data      (rd_job),
        .out_byte      (out_byte),
        .end_of_string (end_of_string),
        .bad_id        (bad_id),
        .run_last      (run_last),
        .empty         (empty),
        .pop           (pop)
    );

endmodule
